[sv/boxcar_average_decimator_defines.svh]
// ----------------------------------------------------------------------------
// Boxcar average decimator assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOXCAR_AVERAGE_DECIMATOR_DEFINES_SVH
`define BOXCAR_AVERAGE_DECIMATOR_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define BXAVG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An overlapping implication from an antecedent to a consequent.
`define BXAVG_ASSERT_IMPLY(name, ante, cons, msg) \
  `BXAVG_ASSERT(name, (ante) |-> (cons), msg)

`endif

[sv/bxavg_pkg.sv]
// ----------------------------------------------------------------------------
// Boxcar average decimator package
// Widths, register indexes, sample format codes and sequencer states.
// ----------------------------------------------------------------------------
package bxavg_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned SUM_W     = 41;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned QUO_W     = SUM_W + FRAC_W;
  localparam int unsigned OUT_W     = 49;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned FMT_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ITER_W    = $clog2(QUO_W);
  localparam int unsigned MAX_GROUP = 256;

  typedef enum logic [FMT_W-1:0] {
    FMT_U8  = 3'd0,
    FMT_U16 = 3'd1,
    FMT_U32 = 3'd2,
    FMT_I8  = 3'd3,
    FMT_I16 = 3'd4,
    FMT_I32 = 3'd5
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_PIXEL = 2'd0,
    CFG_SAMPLE_FORMAT     = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIV,
    ST_FIX
  } state_e;

endpackage

[sv/boxcar_average_decimator.sv]
// ----------------------------------------------------------------------------
// Boxcar average decimator
// Averages each run of N samples into one signed Q.16 word, truncated toward
// zero, using an exact integer sum and a bit-serial divider.
// ----------------------------------------------------------------------------
// Samples arrive on the in channel (in_valid_i, in_ready_o, sample_bits_i)
// and averages leave on the out channel (out_valid_o, out_ready_i,
// average_q16_o). Registers are written on the cfg channel, which is always
// ready: index 0 sets the group length, index 1 the sample format.
// A sample that does not close a group is added to the sum as it is taken, so
// such words are taken back to back. The sample that closes a group starts the
// restoring divider: a first step forms the magnitude, the quotient bits then
// follow one per cycle, and a last step restores the sign. The average is then
// registered and raised on out_valid_o, and in_ready_o is low from the accept
// of that sample until the average is registered.
// The result sits in an output register, so further samples are taken while
// it waits; if the receiver still stalls when the next average is ready, the
// sign stage holds until the output register is free.
// Reset clears the sum, the count and the output valid, and sets the group
// length to one and the format to unsigned 8 bits.
// ----------------------------------------------------------------------------
module boxcar_average_decimator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bxavg_pkg::SAMPLE_W-1:0]     sample_bits_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [bxavg_pkg::OUT_W-1:0] average_q16_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bxavg_pkg::LEN_W-1:0]        cfg_data_i
);
  import bxavg_pkg::*;

  state_e                    state_q, state_d;
  logic [LEN_W-1:0]          spp_q;
  logic [FMT_W-1:0]          fmt_q;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      neg_q, neg_d;
  logic [QUO_W-1:0]          dvd_q, dvd_d;
  logic [CNT_W-1:0]          rem_q, rem_d;
  logic [LEN_W-1:0]          dlen_q, dlen_d;
  logic [ITER_W-1:0]         iter_q, iter_d;
  logic signed [OUT_W-1:0]   res_q, res_d;
  logic                      out_valid_q, out_valid_d;

  logic [LEN_W-1:0]          group_len;
  logic signed [SUM_W-1:0]   sum_new;
  logic [LEN_W-1:0]          cnt_new;
  logic [LEN_W-1:0]          rem_sh;
  logic [LEN_W-1:0]          rem_sub;
  logic [OUT_W-1:0]          quo_lo;

  function automatic logic signed [SUM_W-1:0] decode_sample(
    input logic [SAMPLE_W-1:0] bits,
    input logic [FMT_W-1:0]    fmt
  );
    logic signed [SUM_W-1:0] v;
    case (fmt)
      FMT_U16: v = {{(SUM_W-16){1'b0}}, bits[15:0]};
      FMT_U32: v = {{(SUM_W-32){1'b0}}, bits[31:0]};
      FMT_I8:  v = {{(SUM_W-8){bits[7]}}, bits[7:0]};
      FMT_I16: v = {{(SUM_W-16){bits[15]}}, bits[15:0]};
      FMT_I32: v = {{(SUM_W-32){bits[31]}}, bits[31:0]};
      default: v = {{(SUM_W-8){1'b0}}, bits[7:0]};
    endcase
    return v;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign average_q16_o = res_q;

  always_comb begin
    if (spp_q == '0) begin
      group_len = LEN_W'(1);
    end else if (spp_q > LEN_W'(MAX_GROUP)) begin
      group_len = LEN_W'(MAX_GROUP);
    end else begin
      group_len = spp_q;
    end
  end

  assign sum_new = sum_q + decode_sample(sample_bits_i, fmt_q);
  assign cnt_new = {1'b0, cnt_q} + LEN_W'(1);
  assign rem_sh  = {rem_q, dvd_q[QUO_W-1]};
  assign rem_sub = rem_sh - dlen_q;
  assign quo_lo  = dvd_q[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q <= LEN_W'(1);
      fmt_q <= FMT_U8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SAMPLES_PER_PIXEL: spp_q <= cfg_data_i;
        CFG_SAMPLE_FORMAT:     fmt_q <= cfg_data_i[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dlen_q <= dlen_d;
    iter_q <= iter_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dlen_d      = dlen_q;
    iter_d      = iter_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cnt_new >= group_len) begin
            sum_d   = '0;
            cnt_d   = '0;
            neg_d   = sum_new[SUM_W-1];
            dvd_d   = {sum_new, {FRAC_W{1'b0}}};
            dlen_d  = group_len;
            state_d = ST_ABS;
          end else begin
            sum_d = sum_new;
            cnt_d = cnt_new[CNT_W-1:0];
          end
        end
      end
      ST_ABS: begin
        if (neg_q) begin
          dvd_d = -dvd_q;
        end
        rem_d   = '0;
        iter_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= dlen_q) begin
          rem_d = rem_sub[CNT_W-1:0];
          dvd_d = {dvd_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[CNT_W-1:0];
          dvd_d = {dvd_q[QUO_W-2:0], 1'b0};
        end
        if (iter_q == ITER_W'(QUO_W - 1)) begin
          state_d = ST_FIX;
        end else begin
          iter_d = iter_q + ITER_W'(1);
        end
      end
      ST_FIX: begin
        if (!out_valid_q || out_ready_i) begin
          res_d       = neg_q ? $signed(~quo_lo + OUT_W'(1)) : $signed(quo_lo);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/bxavg_checker.sv]
// ----------------------------------------------------------------------------
// Boxcar average decimator port checker
// Watches the ports of the decimator and flags handshake or sequencing slips.
// ----------------------------------------------------------------------------
`include "boxcar_average_decimator_defines.svh"

module bxavg_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [bxavg_pkg::SAMPLE_W-1:0]     sample_bits_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [bxavg_pkg::OUT_W-1:0] average_q16_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [bxavg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input logic [bxavg_pkg::LEN_W-1:0]        cfg_data_i
);

  logic unused_ok;
  assign unused_ok = ^{sample_bits_i, cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i};

  // A stalled output word keeps its value until it is taken.
  `BXAVG_ASSERT(out_word_held, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(average_q16_o)), "output word dropped or changed while stalled")

  // The input side only stops taking words just after it has taken one.
  `BXAVG_ASSERT_IMPLY(ready_falls_after_accept, $fell(in_ready_o), $past(in_valid_i && in_ready_o), "in_ready_o fell without an accepted word")

  // A new average is only raised at the end of a division, while input is held off.
  `BXAVG_ASSERT_IMPLY(result_after_divide, $rose(out_valid_o), !$past(in_ready_o), "average raised while the divider was idle")

endmodule

bind boxcar_average_decimator bxavg_checker u_bxavg_checker (.*);
